>>> hw/rtl/miller_rabin_prime_test64_top_defines.svh
// ---------------------------------------------------------------------------
// miller_rabin_prime_test64_top_defines.svh
// assertion macros shared by the checker
// ---------------------------------------------------------------------------
`ifndef MILLER_RABIN_PRIME_TEST64_TOP_DEFINES_SVH
`define MILLER_RABIN_PRIME_TEST64_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define MRPT_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mrpt assertion failed");

// next-cycle implication, off during reset
`define MRPT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mrpt assertion failed");

// next-cycle implication, also checked across reset
`define MRPT_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("mrpt assertion failed");

`endif

>>> hw/rtl/mrpt_pkg.sv
// ---------------------------------------------------------------------------
// mrpt_pkg
// types and constants of the 64-bit primality tester
// ---------------------------------------------------------------------------
package mrpt_pkg;

   localparam int TrialCount = 16;
   localparam int BaseCount  = 8;

   // primes used for trial division
   localparam logic [5:0] TrialPrimes [TrialCount] = '{
      6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19,
      6'd23, 6'd29, 6'd31, 6'd37, 6'd41, 6'd43, 6'd47, 6'd53
   };

   // witness bases of the strong probable prime rounds
   localparam logic [4:0] TestBases [BaseCount] = '{
      5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19
   };

   // controller states
   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_TRIAL  = 10'b0000000010,
      ST_DECIDE = 10'b0000000100,
      ST_BINIT  = 10'b0000001000,
      ST_SQ     = 10'b0000010000,
      ST_MUL    = 10'b0000100000,
      ST_NEXT   = 10'b0001000000,
      ST_CHECK  = 10'b0010000000,
      ST_CSQ    = 10'b0100000000,
      ST_RESULT = 10'b1000000000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       trial_step;
      logic       exp_init;
      logic       exp_shift;
      logic       mm_step;
      logic       mm_mul;
      logic [5:0] step_idx;
      logic [2:0] base_idx;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       below_two;
      logic       trial_div;
      logic       trial_eq;
      logic       e_msb;
      logic       x_is_one;
      logic       x_is_nm1;
      logic [6:0] s_val;
   } status_type;

endpackage

>>> hw/rtl/mrpt_if.sv
// ---------------------------------------------------------------------------
// mrpt_if
// request and response channels of the primality tester
// ---------------------------------------------------------------------------
interface mrpt_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink (input valid, input candidate, output ready);
endinterface

interface mrpt_rsp_if;
   logic valid;
   logic ready;
   logic is_prime;

   modport source (output valid, output is_prime, input ready);
   modport sink (input valid, input is_prime, output ready);
endinterface

>>> hw/rtl/mrpt_datapath.sv
// ---------------------------------------------------------------------------
// mrpt_datapath
// operand registers, serial trial division, trailing-zero scan and a
// bit-serial modular multiplier
// ---------------------------------------------------------------------------
module mrpt_datapath
   import mrpt_pkg::*;
(
   input  logic       clock,
   input  logic [63:0] cand,
   input  cmd_type    cmd,
   output status_type status
);

   logic [63:0] n_ff, n_in;
   logic [63:0] d_ff, d_in;
   logic [6:0]  s_ff, s_in;
   logic [63:0] e_ff, e_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] r_ff, r_in;
   logic [5:0]  rem_ff [TrialCount];
   logic [5:0]  rem_in [TrialCount];

   logic [63:0] nm1;
   logic [63:0] b_op;
   logic [63:0] r_base;
   logic [64:0] t_dbl;
   logic [63:0] t_red;
   logic [64:0] t_sum;
   logic [63:0] mm_next;
   logic        n_bit;
   logic [6:0]  rv;
   logic        any_div;
   logic        any_eq;

   assign nm1 = n_ff - 64'd1;

   // trial division: one bit of n per cycle into every remainder lane
   assign n_bit = n_ff[~cmd.step_idx];
   always_comb begin
      for (int i = 0; i < TrialCount; i++) begin
         rv = {((cmd.step_idx == 6'd0) ? 6'd0 : rem_ff[i]), n_bit};
         rem_in[i] = (rv >= {1'b0, TrialPrimes[i]}) ?
                     6'(rv - {1'b0, TrialPrimes[i]}) : rv[5:0];
      end
   end

   // modular multiply step: r = 2r + a*bit mod n, a is x
   assign b_op   = cmd.mm_mul ? {59'd0, TestBases[cmd.base_idx]} : x_ff;
   assign r_base = (cmd.step_idx == 6'd0) ? 64'd0 : r_ff;
   always_comb begin
      t_dbl = {r_base, 1'b0};
      t_red = (t_dbl >= {1'b0, n_ff}) ? 64'(t_dbl - {1'b0, n_ff}) : t_dbl[63:0];
      t_sum = {1'b0, t_red} + {1'b0, x_ff};
      if (b_op[~cmd.step_idx]) begin
         mm_next = (t_sum >= {1'b0, n_ff}) ? 64'(t_sum - {1'b0, n_ff}) : t_sum[63:0];
      end else begin
         mm_next = t_red;
      end
   end

   // register updates
   always_comb begin
      n_in = n_ff;
      d_in = d_ff;
      s_in = s_ff;
      e_in = e_ff;
      x_in = x_ff;
      r_in = r_ff;
      if (cmd.load) begin
         n_in = cand;
         d_in = cand - 64'd1;
         s_in = 7'd0;
      end
      // trailing zeros of n-1 are stripped while trial division runs
      if (cmd.trial_step && !d_ff[0] && s_ff != 7'd64) begin
         d_in = {1'b0, d_ff[63:1]};
         s_in = s_ff + 7'd1;
      end
      if (cmd.exp_init) begin
         e_in = d_ff;
         x_in = 64'd1;
      end
      if (cmd.exp_shift) begin
         e_in = {e_ff[62:0], 1'b0};
      end
      if (cmd.mm_step) begin
         r_in = mm_next;
         if (cmd.step_idx == 6'd63) begin
            x_in = mm_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      d_ff <= d_in;
      s_ff <= s_in;
      e_ff <= e_in;
      x_ff <= x_in;
      r_ff <= r_in;
      for (int i = 0; i < TrialCount; i++) begin
         if (cmd.trial_step) begin
            rem_ff[i] <= rem_in[i];
         end
      end
   end

   // status flags
   always_comb begin
      any_div = 1'b0;
      any_eq  = 1'b0;
      for (int i = 0; i < TrialCount; i++) begin
         any_div = any_div | (rem_ff[i] == 6'd0);
         any_eq  = any_eq | (n_ff == {58'd0, TrialPrimes[i]});
      end
   end

   assign status.below_two = (n_ff[63:1] == 63'd0);
   assign status.trial_div = any_div;
   assign status.trial_eq  = any_eq;
   assign status.e_msb     = e_ff[63];
   assign status.x_is_one  = (x_ff == 64'd1);
   assign status.x_is_nm1  = (x_ff == nm1);
   assign status.s_val     = s_ff;

endmodule

>>> hw/rtl/mrpt_ctrl.sv
// ---------------------------------------------------------------------------
// mrpt_ctrl
// sequencer: trial division, exponentiation per base, squaring checks
// ---------------------------------------------------------------------------
module mrpt_ctrl
   import mrpt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_prime,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [5:0] bit_ff, bit_in;
   logic [6:0] k_ff, k_in;
   logic [2:0] base_ff, base_in;
   logic       res_ff, res_in;
   logic       pass;

   assign pass = (k_ff == 7'd0 && status.x_is_one) || status.x_is_nm1;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      bit_in   = bit_ff;
      k_in     = k_ff;
      base_in  = base_ff;
      res_in   = res_ff;
      cmd      = '0;
      cmd.step_idx = cnt_ff;
      cmd.base_idx = base_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = 6'd0;
               state_in = ST_TRIAL;
            end
         end
         ST_TRIAL: begin
            cmd.trial_step = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            base_in = 3'd0;
            if (status.below_two) begin
               res_in   = 1'b0;
               state_in = ST_RESULT;
            end else if (status.trial_div) begin
               res_in   = status.trial_eq;
               state_in = ST_RESULT;
            end else begin
               state_in = ST_BINIT;
            end
         end
         ST_BINIT: begin
            cmd.exp_init = 1'b1;
            cnt_in   = 6'd0;
            bit_in   = 6'd0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.mm_step = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = status.e_msb ? ST_MUL : ST_NEXT;
            end
         end
         ST_MUL: begin
            cmd.mm_step = 1'b1;
            cmd.mm_mul  = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            cmd.exp_shift = 1'b1;
            if (bit_ff == 6'd63) begin
               k_in     = 7'd0;
               state_in = ST_CHECK;
            end else begin
               bit_in   = bit_ff + 6'd1;
               state_in = ST_SQ;
            end
         end
         ST_CHECK: begin
            cnt_in = 6'd0;
            if (pass) begin
               if (base_ff == 3'(BaseCount - 1)) begin
                  res_in   = 1'b1;
                  state_in = ST_RESULT;
               end else begin
                  base_in  = base_ff + 3'd1;
                  state_in = ST_BINIT;
               end
            end else if (k_ff + 7'd1 == status.s_val) begin
               res_in   = 1'b0;
               state_in = ST_RESULT;
            end else begin
               k_in     = k_ff + 7'd1;
               state_in = ST_CSQ;
            end
         end
         ST_CSQ: begin
            cmd.mm_step = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = ST_CHECK;
            end
         end
         ST_RESULT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      bit_ff  <= bit_in;
      k_ff    <= k_in;
      base_ff <= base_in;
      res_ff  <= res_in;
   end

   // channel handshake
   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = (state_ff == ST_RESULT);
   assign rsp_is_prime = res_ff;

endmodule

>>> hw/rtl/miller_rabin_prime_test64_top.sv
// ---------------------------------------------------------------------------
// miller_rabin_prime_test64_top
// strong probable prime test of a 64-bit number to bases 2 through 19
// ---------------------------------------------------------------------------
// usage:
//   req_chan carries one candidate per beat, rsp_chan one is_prime flag per
//   beat. one candidate is in flight at a time: req_chan.ready is high only
//   while the block is idle, and stays low until the result beat is taken.
// sequence:
//   serial trial division runs first, then a decision step; numbers below
//   2 or with a prime factor up to 53 answer there. other candidates run
//   up to eight rounds, one per base; a round squares for each of the 64
//   exponent bits, multiplies by the base for each set bit of d, and then
//   runs up to s - 1 final squarings, s the trailing zeros of n - 1.
//   every modular product goes through one bit-serial multiplier, one
//   multiplier bit per cycle.
// reset:
//   synchronous, active high; returns to idle and drops any work in flight.
// stall:
//   the result beat holds its flag until rsp_chan.ready is seen high.
// ---------------------------------------------------------------------------
module miller_rabin_prime_test64_top
   import mrpt_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input logic        clock,
   input logic        reset,
   mrpt_req_if.sink   req_chan,
   mrpt_rsp_if.source rsp_chan
);

   localparam logic [63:0] WordMask = {64{1'b1}} >> (64 - WORD_BITS);

   cmd_type    cmd;
   status_type status;
   logic [63:0] cand_masked;

   // candidate cut to the configured word width
   assign cand_masked = req_chan.candidate & WordMask;

   mrpt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .rsp_is_prime (rsp_chan.is_prime),
      .status       (status),
      .cmd          (cmd)
   );

   mrpt_datapath u_datapath (
      .clock  (clock),
      .cand   (cand_masked),
      .cmd    (cmd),
      .status (status)
   );

endmodule

>>> hw/rtl/mrpt_checker.sv
// ---------------------------------------------------------------------------
// mrpt_checker
// port-level checks of the primality tester, bound to the top level
// ---------------------------------------------------------------------------
`include "miller_rabin_prime_test64_top_defines.svh"

module mrpt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_is_prime
);

   // a stalled result beat keeps its flag
   `MRPT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_is_prime))

   // one candidate at a time: no new beat right after one is taken
   `MRPT_ASSERT_NEXT(a_one_inflight, req_valid && req_ready, !req_ready)

   // trial division alone takes many cycles, so no answer follows at once
   `MRPT_ASSERT_NEXT(a_no_instant_rsp, req_valid && req_ready, !rsp_valid)

   // request side is closed while a result waits
   `MRPT_ASSERT_NOW(a_rsp_excl, rsp_valid, !req_ready)

   // reset leaves the block idle and empty
   `MRPT_ASSERT_NEXT_ALWAYS(a_reset_idle, reset, req_ready && !rsp_valid)

endmodule

bind miller_rabin_prime_test64_top mrpt_checker u_mrpt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_is_prime (rsp_chan.is_prime)
);

>>> bench/mrpt_tb_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mrpt_tb_if
// the bench drives the request and response channel interfaces of the rtl
// folder directly, so no bench-only channel types live here
// ---------------------------------------------------------------------------

>>> bench/miller_rabin_prime_test64_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// miller_rabin_prime_test64_top_tb
// checks the primality flag of each candidate against a strong probable
// prime test to bases 2..19 done with plain 128-bit modular products;
// directed edge values first, then random candidates with random stalls
// ---------------------------------------------------------------------------
module miller_rabin_prime_test64_top_tb
   import mrpt_pkg::*;
();

   localparam int StallLimit = 300000;
   localparam int RandomItems = 120;
   localparam int CalmItems = 20;

   logic clock;
   logic reset;
   bit   calm;
   bit   long_hold;
   int   quiet_cycles;

   mrpt_req_if req_chan ();
   mrpt_rsp_if rsp_chan ();

   miller_rabin_prime_test64_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // modular product through a full 128-bit product
   function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return 64'(prod % {64'd0, m});
   endfunction

   // flag expected for one candidate
   function automatic bit primality_of(logic [63:0] n);
      logic [63:0] d, x, b, e;
      int          s;
      bit          composite;
      if (n < 2) return 1'b0;
      for (int i = 0; i < TrialCount; i++) begin
         if (n % 64'(TrialPrimes[i]) == 0) return n == 64'(TrialPrimes[i]);
      end
      d = n - 1;
      s = 0;
      while (!d[0]) begin
         d = d >> 1;
         s++;
      end
      for (int i = 0; i < BaseCount; i++) begin
         // x = base^d mod n
         x = 64'd1;
         b = 64'(TestBases[i]);
         e = d;
         while (e != 0) begin
            if (e[0]) x = mul_mod(x, b, n);
            b = mul_mod(b, b, n);
            e = e >> 1;
         end
         if (x != 64'd1) begin
            composite = 1'b1;
            for (int r = 0; r < s; r++) begin
               if (x == n - 1) begin
                  composite = 1'b0;
                  break;
               end
               x = mul_mod(x, x, n);
            end
            if (composite) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // store of expected flags in arrival order
   class prime_flag_board;
      bit          flags_due[$];
      logic [63:0] cands_due[$];
      int          errors;

      function void note_candidate(logic [63:0] cand);
         flags_due.push_back(primality_of(cand));
         cands_due.push_back(cand);
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_flag(bit got);
         bit          want;
         logic [63:0] cand;
         if (flags_due.size() == 0) begin
            report($sformatf("unexpected result beat, is_prime=%0b", got));
         end else begin
            want = flags_due.pop_front();
            cand = cands_due.pop_front();
            if (want !== got)
               report($sformatf("candidate %0d: is_prime %0b, expected %0b", cand, got, want));
         end
      endtask
   endclass

   prime_flag_board board = new();

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // monitor both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) board.note_candidate(req_chan.candidate);
         if (rsp_chan.valid && rsp_chan.ready) board.check_flag(rsp_chan.is_prime);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("timeout: no beat for %0d cycles", StallLimit);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one candidate beat, valid stays up afterwards
   task send_candidate(logic [63:0] cand);
      req_chan.valid <= 1'b1;
      req_chan.candidate <= cand;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task sender_gap();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
   endtask

   function automatic logic [63:0] random_candidate();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 9)) inside
         [0:1]: return wide >> $urandom_range(0, 63);
         2: return 64'($urandom_range(1, 65535) | 1) * 64'($urandom_range(1, 65535) | 1);
         3: return 64'($urandom_range(0, 4000));
         default: return wide;
      endcase
   endfunction

   // receiver with random stalls and one long hold-off
   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (400) @(negedge clock);
            long_hold = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic [63:0] directed[$];
      directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd53, 64'd55, 64'd59, 64'd61,
                   64'd2809, 64'd561, 64'd2047, 64'd25326001, 64'd3215031751,
                   64'd4294967291, 64'd1000003, 64'h8000_0000_0000_0000,
                   64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC5,
                   64'hFFFF_FFFF_FFFF_FFC3, 64'h5555_5555_5555_5555};
      reset = 1'b1;
      calm = 1'b0;
      long_hold = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.candidate = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed edge values
      foreach (directed[i]) begin
         send_candidate(directed[i]);
         sender_gap();
      end

      // random candidates
      for (int i = 0; i < RandomItems; i++) begin
         if (i == 10) long_hold = 1'b1;
         if (i == 60) begin
            // drain everything before going on
            req_chan.valid <= 1'b0;
            while (board.flags_due.size() != 0) @(negedge clock);
         end
         if (i == RandomItems - CalmItems) calm = 1'b1;
         send_candidate(random_candidate());
         sender_gap();
      end
      req_chan.valid <= 1'b0;

      while (board.flags_due.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (board.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
